>>> hdl/tis_pkg.sv
// shared constants, types and helpers of the trie block
package tis_pkg;

	localparam int NODE_COUNT  = 8192;
	localparam int ALPHABET    = 26;
	localparam int MAX_KEY_LEN = 32;

	localparam int NODE_W  = $clog2(NODE_COUNT);
	localparam int ALLOC_W = $clog2(NODE_COUNT + 1);
	localparam int LINK_N  = NODE_COUNT * ALPHABET;
	localparam int LINK_AW = $clog2(LINK_N);
	localparam int DEPTH_W = $clog2(MAX_KEY_LEN + 1);
	localparam int PIDX_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int ENT_W   = ALPHABET + 1;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_LONG = 2'd3;

	typedef struct packed {
		logic                mark;
		logic [ALPHABET-1:0] mask;
	} node_ent_t;

	function automatic logic [LINK_AW-1:0] link_addr(input logic [NODE_W-1:0] node,
			input logic [4:0] letter);
		logic [LINK_AW-1:0] prod;
		prod = LINK_AW'(node) * LINK_AW'(ALPHABET);
		return prod + LINK_AW'(letter);
	endfunction

	function automatic logic [ALPHABET-1:0] letter_bit(input logic [4:0] letter);
		return ALPHABET'(1) << letter;
	endfunction

endpackage

>>> hdl/tis_if.sv
// item channels of the trie block
interface tis_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [4:0] letter;
	logic       last_letter;
	logic       empty_key;
	modport source (output valid, opcode, letter, last_letter, empty_key, input ready);
	modport sink (input valid, opcode, letter, last_letter, empty_key, output ready);
endinterface

interface tis_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [13:0] nodes_used;
	modport source (output valid, status, nodes_used, input ready);
	modport sink (input valid, status, nodes_used, output ready);
endinterface

>>> hdl/tis_ram.sv
// generic simple dual port ram with registered read
module tis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hdl/trie_insert_search_delete.sv
// top level of the trie block: key walk, key end and delete pruning
// A 26-letter trie in a pool of NODE_COUNT nodes. Each node has one word of
// node memory (word mark and a valid bit per letter) and ALPHABET links in a
// link memory; a link counts only while its valid bit is set, so the link
// memory needs no clearing and a new node costs one write of its node word.
// No clearing pass follows reset. A letter that follows an existing link
// passes S_IDLE (node and link read) and S_WALK, one that allocates a node
// adds S_CLR, a flagged letter only S_IDLE; a key end passes S_FRD and S_FIN,
// and a delete adds S_PRD and S_PWR per pruned level. One item is worked on
// at a time; the next one is taken while a result waits.
module trie_insert_search_delete
	import tis_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tis_req_if.sink    req,
	tis_rsp_if.source  rsp
);
	typedef enum logic [2:0] {
		S_IDLE, S_WALK, S_CLR, S_FRD, S_FIN, S_PRD, S_PWR
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [4:0]         letter_q;
	logic               last_q;
	logic [NODE_W-1:0]  cursor_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               miss_q;
	logic [1:0]         ovf_q;
	logic [ALLOC_W-1:0] alloc_q;
	logic               root_init_q;
	logic [NODE_W-1:0]  rd_node_q;
	logic [1:0]         stat_q;
	logic [4:0]         bit_q;
	logic [NODE_W-1:0]  path_node_q [MAX_KEY_LEN];
	logic [4:0]         path_let_q [MAX_KEY_LEN];
	logic               out_v_q;
	logic [1:0]         out_st_q;
	logic [13:0]        out_cnt_q;

	logic               n_we, n_re, c_we, c_re;
	logic [NODE_W-1:0]  n_waddr, n_raddr;
	node_ent_t          n_wdata, n_raw, n_ent;
	logic [LINK_AW-1:0] c_waddr, c_raddr;
	logic [NODE_W-1:0]  c_rdata;
	logic               out_free;
	logic               out_load;
	logic [ALPHABET-1:0] pmask;
	logic [DEPTH_W-1:0] depth_m1;
	logic [PIDX_W-1:0]  pidx;

	tis_ram #(.WIDTH(ENT_W), .DEPTH(NODE_COUNT)) u_node_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_raw)
	);

	tis_ram #(.WIDTH(NODE_W), .DEPTH(LINK_N)) u_link_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(alloc_q[NODE_W-1:0]),
		.re(c_re), .raddr(c_raddr), .rdata(c_rdata)
	);

	assign out_free = !out_v_q || rsp.ready;
	assign n_ent    = (rd_node_q == '0 && !root_init_q) ? '0 : n_raw;
	assign pmask    = n_ent.mask & ~letter_bit(bit_q);
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign pidx     = depth_m1[PIDX_W-1:0];

	// a result is loaded this cycle
	assign out_load = out_free &&
		((state_q == S_FIN && !(ovf_q == 2'd0 && !miss_q && op_q == OP_DELETE &&
			depth_q != '0 && n_ent.mask == '0)) ||
		(state_q == S_PWR && !(!n_ent.mark && pmask == '0 && depth_q != '0)));

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_st_q;
	assign rsp.nodes_used = out_cnt_q;

	// memory ports
	always_comb begin
		n_re    = 1'b0;
		n_raddr = cursor_q;
		c_re    = 1'b0;
		c_raddr = link_addr(cursor_q, req.letter);
		n_we    = 1'b0;
		n_waddr = cursor_q;
		n_wdata = n_ent;
		c_we    = 1'b0;
		c_waddr = link_addr(cursor_q, letter_q);
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && !req.empty_key && !miss_q && ovf_q == 2'd0 &&
						32'(req.letter) < ALPHABET && 32'(depth_q) < MAX_KEY_LEN) begin
					n_re = 1'b1;
					c_re = 1'b1;
				end
			end
			S_WALK: begin
				if (!n_ent.mask[letter_q] && op_q == OP_INSERT &&
						32'(alloc_q) < NODE_COUNT) begin
					n_we         = 1'b1;
					n_wdata.mask = n_ent.mask | letter_bit(letter_q);
					c_we         = 1'b1;
				end
			end
			S_CLR: begin
				n_we    = 1'b1;
				n_wdata = '0;
			end
			S_FRD: begin
				n_re = 1'b1;
			end
			S_FIN: begin
				if (out_free && !miss_q && ovf_q == 2'd0 &&
						(op_q == OP_INSERT || op_q == OP_DELETE)) begin
					n_we         = 1'b1;
					n_wdata.mark = (op_q == OP_INSERT);
				end
			end
			S_PRD: begin
				n_re    = 1'b1;
				n_raddr = path_node_q[pidx];
			end
			S_PWR: begin
				if (out_free) begin
					n_we         = 1'b1;
					n_waddr      = rd_node_q;
					n_wdata.mask = pmask;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			depth_q     <= '0;
			miss_q      <= 1'b0;
			ovf_q       <= 2'd0;
			alloc_q     <= ALLOC_W'(1);
			root_init_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			if (n_we && n_waddr == '0) begin
				root_init_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.opcode;
						letter_q <= req.letter;
						last_q   <= req.last_letter;
						if (req.empty_key) begin
							cursor_q <= '0;
							depth_q  <= '0;
							miss_q   <= 1'b0;
							ovf_q    <= 2'd0;
							state_q  <= S_FRD;
						end else if (miss_q || ovf_q != 2'd0) begin
							state_q <= req.last_letter ? S_FRD : S_IDLE;
						end else if (32'(req.letter) >= ALPHABET) begin
							miss_q  <= 1'b1;
							state_q <= req.last_letter ? S_FRD : S_IDLE;
						end else if (32'(depth_q) >= MAX_KEY_LEN) begin
							ovf_q   <= ST_LONG;
							state_q <= req.last_letter ? S_FRD : S_IDLE;
						end else begin
							path_node_q[depth_q[PIDX_W-1:0]] <= cursor_q;
							path_let_q[depth_q[PIDX_W-1:0]]  <= req.letter;
							depth_q   <= depth_q + DEPTH_W'(1);
							rd_node_q <= cursor_q;
							state_q   <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (n_ent.mask[letter_q]) begin
						cursor_q <= c_rdata;
						state_q  <= last_q ? S_FRD : S_IDLE;
					end else if (op_q != OP_INSERT) begin
						miss_q  <= 1'b1;
						state_q <= last_q ? S_FRD : S_IDLE;
					end else if (32'(alloc_q) >= NODE_COUNT) begin
						ovf_q   <= ST_FULL;
						state_q <= last_q ? S_FRD : S_IDLE;
					end else begin
						cursor_q <= alloc_q[NODE_W-1:0];
						alloc_q  <= alloc_q + ALLOC_W'(1);
						state_q  <= S_CLR;
					end
				end
				S_CLR: begin
					state_q <= last_q ? S_FRD : S_IDLE;
				end
				S_FRD: begin
					rd_node_q <= cursor_q;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						if (ovf_q != 2'd0) begin
							stat_q <= ovf_q;
						end else if (miss_q) begin
							stat_q <= ST_MISS;
						end else if (op_q == OP_INSERT) begin
							stat_q <= ST_DONE;
						end else begin
							stat_q <= n_ent.mark ? ST_DONE : ST_MISS;
						end
						if (ovf_q == 2'd0 && !miss_q && op_q == OP_DELETE &&
								depth_q != '0 && n_ent.mask == '0) begin
							state_q <= S_PRD;
						end else begin
							out_v_q   <= 1'b1;
							out_cnt_q <= 14'(alloc_q);
							if (ovf_q != 2'd0) begin
								out_st_q <= ovf_q;
							end else if (miss_q) begin
								out_st_q <= ST_MISS;
							end else if (op_q == OP_INSERT) begin
								out_st_q <= ST_DONE;
							end else begin
								out_st_q <= n_ent.mark ? ST_DONE : ST_MISS;
							end
							cursor_q <= '0;
							depth_q  <= '0;
							miss_q   <= 1'b0;
							ovf_q    <= 2'd0;
							state_q  <= S_IDLE;
						end
					end
				end
				S_PRD: begin
					rd_node_q <= path_node_q[pidx];
					bit_q     <= path_let_q[pidx];
					depth_q   <= depth_m1;
					state_q   <= S_PWR;
				end
				S_PWR: begin
					if (out_free) begin
						if (!n_ent.mark && pmask == '0 && depth_q != '0) begin
							state_q <= S_PRD;
						end else begin
							out_v_q   <= 1'b1;
							out_st_q  <= stat_q;
							out_cnt_q <= 14'(alloc_q);
							cursor_q  <= '0;
							depth_q   <= '0;
							miss_q    <= 1'b0;
							ovf_q     <= 2'd0;
							state_q   <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> verif/trie_insert_search_delete_test.sv
// testbench of the trie block: directed and random keys checked against a behavioral trie
`timescale 1ns / 100ps

module trie_insert_search_delete_test;
	import tis_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] nodes_used;
	} trie_reply_t;

	class trie_board;
		trie_reply_t pending[$];
		int errors;
		logic [12:0] links[int];
		bit          marks[int];
		int          kids[int];
		int          next_node;
		int          cur;
		int          depth;
		bit          miss;
		logic [1:0]  ovf;
		int          path_n[MAX_KEY_LEN];
		int          path_l[MAX_KEY_LEN];

		function new();
			errors = 0;
			next_node = 1;
			cur = 0;
			depth = 0;
			miss = 0;
			ovf = 0;
		endfunction

		function int link_of(int n, int l);
			if (links.exists(n * ALPHABET + l)) return links[n * ALPHABET + l];
			return 0;
		endfunction

		function void walk(logic [1:0] op, int l);
			int ch;
			if (miss || ovf != 0) return;
			if (l >= ALPHABET) begin
				miss = 1;
				return;
			end
			if (depth >= MAX_KEY_LEN) begin
				ovf = ST_LONG;
				return;
			end
			path_n[depth] = cur;
			path_l[depth] = l;
			depth++;
			ch = link_of(cur, l);
			if (ch == 0) begin
				if (op != OP_INSERT) begin
					miss = 1;
					return;
				end
				if (next_node >= NODE_COUNT) begin
					ovf = ST_FULL;
					return;
				end
				ch = next_node++;
				marks[ch] = 0;
				kids[ch] = 0;
				for (int i = 0; i < ALPHABET; i++) links.delete(ch * ALPHABET + i);
				links[cur * ALPHABET + l] = ch;
				kids[cur] = (kids.exists(cur) ? kids[cur] : 0) + 1;
			end
			cur = ch;
		endfunction

		function logic [1:0] finish(logic [1:0] op);
			logic [1:0] st;
			int n, d, p;
			n = cur;
			d = depth;
			if (ovf != 0) st = ovf;
			else if (miss) st = ST_MISS;
			else if (op == OP_INSERT) begin
				marks[n] = 1;
				st = ST_DONE;
			end else if (op == OP_DELETE) begin
				st = (marks.exists(n) && marks[n]) ? ST_DONE : ST_MISS;
				marks[n] = 0;
				while (d > 0 && !marks[n] && (!kids.exists(n) || kids[n] == 0)) begin
					d--;
					p = path_n[d];
					links.delete(p * ALPHABET + path_l[d]);
					if (kids.exists(p) && kids[p] > 0) kids[p]--;
					n = p;
					if (!marks.exists(n)) marks[n] = 0;
				end
			end else st = (marks.exists(n) && marks[n]) ? ST_DONE : ST_MISS;
			cur = 0;
			depth = 0;
			miss = 0;
			ovf = 0;
			return st;
		endfunction

		function void note_item(logic [1:0] op, logic [4:0] l, logic last, logic empty);
			trie_reply_t r;
			if (empty) begin
				cur = 0;
				depth = 0;
				miss = 0;
				ovf = 0;
			end else begin
				walk(op, int'(l));
				if (!last) return;
			end
			r.status = finish(op);
			r.nodes_used = 14'(next_node);
			pending.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic [13:0] used);
			trie_reply_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected reply status %0d nodes %0d", st, used);
				return;
			end
			e = pending.pop_front();
			if (e.status !== st || e.nodes_used !== used) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected status %0d nodes %0d, got status %0d nodes %0d",
						e.status, e.nodes_used, st, used);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tis_req_if req ();
	tis_rsp_if rsp ();
	trie_board board;
	int idle_cycles;
	bit timed_out;

	trie_insert_search_delete dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	task send_item(logic [1:0] op, logic [4:0] l, logic last, logic empty);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.opcode <= op;
		req.letter <= l;
		req.last_letter <= last;
		req.empty_key <= empty;
		do @(posedge clk); while (!req.ready);
		board.note_item(op, l, last, empty);
	endtask

	task send_key(logic [1:0] op, int len, int alpha);
		for (int i = 0; i < len; i++)
			send_item(op, 5'($urandom_range(0, alpha - 1)), i == len - 1, 0);
	endtask

	task send_word(logic [1:0] op, logic [4:0] w[$]);
		foreach (w[i]) send_item(op, w[i], i == w.size() - 1, 0);
	endtask

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) board.check_reply(rsp.status, rsp.nodes_used);
	end

	int rgap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
			rgap = 0;
		end else if (rgap > 0) begin
			rgap--;
			rsp.ready <= 0;
		end else begin
			rsp.ready <= 1;
			if (rsp.valid && rsp.ready) rgap = gap_len();
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 20000 && !timed_out) begin
			timed_out = 1;
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [4:0] w[$];
		int len;
		board = new();
		idle_cycles = 0;
		timed_out = 0;
		arst_n = 0;
		req.valid = 0;
		req.opcode = 0;
		req.letter = 0;
		req.last_letter = 0;
		req.empty_key = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send_item(OP_SEARCH, 0, 1, 1);
		send_item(OP_INSERT, 0, 1, 1);
		send_item(OP_SEARCH, 31, 0, 1);
		send_item(OP_DELETE, 0, 1, 1);
		send_item(OP_SEARCH, 0, 1, 1);
		w = '{0, 25, 12};
		send_word(OP_INSERT, w);
		send_word(OP_SEARCH, w);
		send_word(OP_DELETE, w);
		send_word(OP_SEARCH, w);
		send_word(OP_DELETE, w);
		send_word(OP_INSERT, w);
		send_word(OP_RSVD, w);
		send_item(OP_INSERT, 26, 1, 0);
		send_item(OP_SEARCH, 31, 1, 0);
		send_item(OP_INSERT, 3, 0, 0);
		send_item(OP_SEARCH, 3, 1, 0);
		send_item(OP_INSERT, 4, 0, 0);
		send_item(OP_INSERT, 4, 0, 1);
		send_key(OP_INSERT, MAX_KEY_LEN, 26);
		send_key(OP_INSERT, MAX_KEY_LEN + 2, 26);
		// random
		for (int k = 0; k < 110; k++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 4);
			w = {};
			for (int i = 0; i < len; i++) w.push_back(5'($urandom_range(0, 3)));
			case ($urandom_range(0, 9))
				0: send_item(2'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
				1: send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1, 0);
				2, 3, 4: send_word(OP_INSERT, w);
				5, 6: send_word(OP_SEARCH, w);
				7, 8: send_word(OP_DELETE, w);
				default: foreach (w[i]) send_item(2'($urandom_range(0, 3)), w[i],
						i == w.size() - 1, 0);
			endcase
		end
		w = '{0, 25, 12};
		send_word(OP_SEARCH, w);
		send_word(OP_DELETE, w);
		send_word(OP_INSERT, w);
		send_item(OP_INSERT, 0, 1, 1);
		send_item(OP_SEARCH, 0, 1, 1);
		req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/tis_pkg.sv
hdl/tis_if.sv
hdl/tis_ram.sv
hdl/trie_insert_search_delete.sv
verif/trie_insert_search_delete_test.sv
